// ===== rtl/ffr_pkg.sv =====
// Package for the fixed-length frame receiver: payload widths, register
// indexes, shared structs and the bar-level function. Depends on nothing.
package ffr_pkg;

  // Field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BarW    = 5;
  localparam int unsigned CountW  = 16;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgStartByte    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEndByte      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBoardAddress = 2'd2;

  // Register reset values.
  localparam logic [ByteW-1:0] StartByteRst    = 8'hFE;
  localparam logic [ByteW-1:0] EndByteRst      = 8'hFF;
  localparam logic [ByteW-1:0] BoardAddressRst = 8'h00;

  // Frame positions of the bytes that are kept.
  localparam logic [PosW-1:0] PosAddress = 6'd2;
  localparam logic [PosW-1:0] PosCommand = 6'd3;
  localparam logic [PosW-1:0] PosPayload = 6'd4;

  // Bar scaling: 27 segments for 100 percent.
  localparam logic [BarW-1:0]  BarFull    = 5'd27;
  localparam logic [ByteW-1:0] BarPercent = 8'd100;
  // 27/100 as a fixed-point reciprocal; exact floor for every payload up to 100.
  localparam int unsigned      BarShift   = 19;
  localparam logic [17:0]      BarRecip   = 18'd141561;
  localparam int unsigned      BarProdW   = 26;

  // Current configuration register values.
  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] end_byte;
    logic [ByteW-1:0] board_address;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    logic              frame_bad;
    logic [ByteW-1:0]  command;
    logic [ByteW-1:0]  payload;
    logic [BarW-1:0]   bar_level;
    logic [CountW-1:0] good_count;
  } result_t;

  // Bar level: full above 100 percent, otherwise floor(p * 27 / 100).
  function automatic logic [BarW-1:0] bar_of(input logic [ByteW-1:0] p);
    logic [BarProdW-1:0] prod;
    prod = BarProdW'(p) * BarProdW'(BarRecip);
    if (p > BarPercent) begin
      return BarFull;
    end
    return BarW'(prod >> BarShift);
  endfunction

endpackage

// ===== rtl/ffr_in_if.sv =====
// Byte input channel of the frame receiver.
// Depends on ffr_pkg for the byte width.
interface ffr_in_if;
  logic                     valid;
  logic                     ready;
  logic [ffr_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/ffr_out_if.sv =====
// Result channel of the frame receiver.
// Depends on ffr_pkg for the field widths.
interface ffr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      frame_bad;
  logic [ffr_pkg::ByteW-1:0]  command;
  logic [ffr_pkg::ByteW-1:0]  payload;
  logic [ffr_pkg::BarW-1:0]   bar_level;
  logic [ffr_pkg::CountW-1:0] good_count;

  modport source (output valid, output frame_bad, output command, output payload,
                  output bar_level, output good_count, input ready);
  modport sink (input valid, input frame_bad, input command, input payload,
                input bar_level, input good_count, output ready);
endinterface

// ===== rtl/ffr_cfg_if.sv =====
// Configuration write channel of the frame receiver.
// Depends on ffr_pkg for the index and data widths.
interface ffr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ffr_pkg::CfgIdxW-1:0] index;
  logic [ffr_pkg::ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ffr_cfg_regs.sv =====
// Configuration registers of the frame receiver: start byte, end byte and
// board address. Depends on ffr_pkg and ffr_cfg_if.
module ffr_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  ffr_cfg_if.sink       cfg_i,
  output ffr_pkg::cfg_t cfg_o
);

  ffr_pkg::cfg_t cfg_d, cfg_q;
  logic          wr_en;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_i.index)
        ffr_pkg::CfgStartByte:    cfg_d.start_byte    = cfg_i.data;
        ffr_pkg::CfgEndByte:      cfg_d.end_byte      = cfg_i.data;
        ffr_pkg::CfgBoardAddress: cfg_d.board_address = cfg_i.data;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= ffr_pkg::StartByteRst;
      cfg_q.end_byte      <= ffr_pkg::EndByteRst;
      cfg_q.board_address <= ffr_pkg::BoardAddressRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ffr_parser.sv =====
// Frame parser: tracks the frame position, keeps the address, command and
// payload bytes and forms the result on the closing byte. Depends on ffr_pkg.
module ffr_parser #(
  parameter int unsigned FRAME_LEN = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [ffr_pkg::ByteW-1:0] byte_i,
  input  ffr_pkg::cfg_t             cfg_i,
  output logic                      res_valid_o,
  output ffr_pkg::result_t          res_o
);

  localparam logic [ffr_pkg::PosW-1:0] LastPos = ffr_pkg::PosW'(FRAME_LEN - 1);

  logic                        in_frame_d, in_frame_q;
  logic [ffr_pkg::PosW-1:0]    pos_d, pos_q;
  logic [ffr_pkg::ByteW-1:0]   addr_d, addr_q;
  logic [ffr_pkg::ByteW-1:0]   cmd_d, cmd_q;
  logic [ffr_pkg::ByteW-1:0]   pay_d, pay_q;
  logic [ffr_pkg::CountW-1:0]  good_d, good_q;
  logic                        bad;

  // The closing byte is checked against the end byte and the address kept.
  assign bad = !((byte_i == cfg_i.end_byte) && (addr_q == cfg_i.board_address));

  // Next state for one byte.
  always_comb begin
    in_frame_d  = in_frame_q;
    pos_d       = pos_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    pay_d       = pay_q;
    good_d      = good_q;
    res_valid_o = 1'b0;
    if (step_i) begin
      if (!in_frame_q) begin
        if (byte_i == cfg_i.start_byte) begin
          in_frame_d = 1'b1;
          pos_d      = ffr_pkg::PosW'(1);
        end
      end else begin
        if (pos_q == ffr_pkg::PosAddress) begin
          addr_d = byte_i;
        end else if (pos_q == ffr_pkg::PosCommand) begin
          cmd_d = byte_i;
        end else if (pos_q == ffr_pkg::PosPayload) begin
          pay_d = byte_i;
        end
        if (pos_q != LastPos) begin
          pos_d = pos_q + ffr_pkg::PosW'(1);
        end else begin
          res_valid_o = 1'b1;
          in_frame_d  = 1'b0;
          pos_d       = '0;
          if (!bad) begin
            good_d = good_q + ffr_pkg::CountW'(1);
          end
        end
      end
    end
  end

  // Result fields; only meaningful while res_valid_o is high.
  always_comb begin
    res_o.frame_bad  = bad;
    res_o.command    = cmd_q;
    res_o.payload    = pay_q;
    res_o.bar_level  = ffr_pkg::bar_of(pay_q);
    res_o.good_count = good_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      addr_q     <= '0;
      cmd_q      <= '0;
      pay_q      <= '0;
      good_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      addr_q     <= addr_d;
      cmd_q      <= cmd_d;
      pay_q      <= pay_d;
      good_q     <= good_d;
    end
  end

endmodule

// ===== rtl/ffr_out_stage.sv =====
// Result register of the frame receiver that drives the result channel.
// Depends on ffr_pkg and ffr_out_if.
module ffr_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ffr_pkg::result_t res_i,
  output logic             space_o,
  ffr_out_if.source        res_o
);

  logic             valid_d, valid_q;
  ffr_pkg::result_t res_q;

  // The register can take a new result when empty or being drained.
  assign space_o = !valid_q || res_o.ready;
  assign valid_d = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.frame_bad  = res_q.frame_bad;
  assign res_o.command    = res_q.command;
  assign res_o.payload    = res_q.payload;
  assign res_o.bar_level  = res_q.bar_level;
  assign res_o.good_count = res_q.good_count;

endmodule

// ===== rtl/fixed_frame_receiver.sv =====
// Fixed-length frame receiver top level: input register, parser, result register.
// Depends on ffr_pkg, the channel interfaces, ffr_cfg_regs, ffr_parser, ffr_out_stage.
//
// The block takes one byte per cycle on rx_i unless it stalls. Bytes are ignored
// until the start byte, which opens a frame of FRAME_LEN bytes counted from
// the start byte itself; bytes 2, 3 and 4 of the frame are kept as address,
// command and payload. The closing byte yields one transaction on res_o
// after it passes first the input register and then the single-pass
// parser into the result register. While a result waits on res_o, the
// next byte is still taken into the input register; the input stalls
// only when both registers are full. Configuration writes on cfg_i are
// taken every cycle.
module fixed_frame_receiver #(
  parameter int unsigned FRAME_LEN = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ffr_in_if.sink    rx_i,
  ffr_out_if.source res_o,
  ffr_cfg_if.sink   cfg_i
);

  ffr_pkg::cfg_t             cfg;
  ffr_pkg::result_t          res;
  logic                      res_valid;
  logic                      out_space;
  logic                      step;
  logic                      in_valid_d, in_valid_q;
  logic [ffr_pkg::ByteW-1:0] in_byte_q;
  logic                      rx_take;

  // Input register: the byte moves on whenever the result register has room.
  assign step       = in_valid_q && out_space;
  assign rx_i.ready = !in_valid_q || out_space;
  assign rx_take    = rx_i.valid && rx_i.ready;
  assign in_valid_d = rx_take || (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  ffr_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ffr_parser #(
    .FRAME_LEN (FRAME_LEN)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ffr_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .space_o (out_space),
    .res_o   (res_o)
  );

endmodule
